/* hdl/assert_macros.svh */
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

/* hdl/rpss_pkg.sv */
package rpss_pkg;

  localparam int unsigned COORD_BITS_DEF = 21;
  localparam int unsigned CoordW = 21;
  // Widest coordinate slice the core can use; inputs are sign-extended to it.
  localparam int unsigned CoordMaxW = 24;
  localparam int unsigned ScaleW = 48;
  localparam int unsigned TermW = 32;
  localparam int unsigned ProbW = 17;
  localparam int unsigned CfgIdxW = 1;
  // Six squares of CoordMaxW-bit differences.
  localparam int unsigned SumW = 2 * CoordMaxW + 3;

  localparam logic [CfgIdxW-1:0] CFG_DIST_SCALE = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_CONF_SCALE = 1'b1;

  localparam logic [31:0] Ln2Q24 = 32'd11629080;
  // floor(2^32 / ln2 in Q8.24); the quotient it gives is low by at most one.
  localparam logic [31:0] Ln2RecipQ32 = 32'd369;
  localparam logic [31:0] ExpFlush = 32'd186227098;
  localparam logic [31:0] OneQ24 = 32'd16777216;
  localparam logic [31:0] TermSat = 32'h8000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_SCALE,
    ST_EXP_K,
    ST_EXP_MUL,
    ST_EXP_DIV,
    ST_OUT
  } state_e;

  // ceil(2^27 / n) for n = 1..7; a multiply and a shift by 27 then give the
  // exact quotient for any dividend below 2^24.
  function automatic logic [31:0] recip_q27(input logic [2:0] n);
    logic [31:0] r;
    begin
      unique case (n)
        3'd1: r = 32'h0800_0000;
        3'd2: r = 32'h0400_0000;
        3'd3: r = 32'h02AA_AAAB;
        3'd4: r = 32'h0200_0000;
        3'd5: r = 32'h0199_999A;
        3'd6: r = 32'h0155_5556;
        3'd7: r = 32'h0124_924A;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction

endpackage

/* hdl/rpss_in_if.sv */
interface rpss_in_if
  import rpss_pkg::*;
  ();
  logic valid;
  logic ready;
  logic signed [CoordW-1:0] first_x;
  logic signed [CoordW-1:0] first_y;
  logic signed [CoordW-1:0] first_z;
  logic signed [CoordW-1:0] second_x;
  logic signed [CoordW-1:0] second_y;
  logic signed [CoordW-1:0] second_z;
  logic is_first;
  logic is_last;
  modport source (output valid, first_x, first_y, first_z, second_x, second_y,
                  second_z, is_first, is_last, input ready);
  modport sink (input valid, first_x, first_y, first_z, second_x, second_y,
                second_z, is_first, is_last, output ready);
endinterface

interface rpss_out_if
  import rpss_pkg::*;
  ();
  logic valid;
  logic ready;
  logic signed [TermW-1:0] dist_term;
  logic signed [TermW-1:0] conf_term;
  logic [ProbW-1:0] probability;
  logic run_last;
  modport source (output valid, dist_term, conf_term, probability, run_last,
                  input ready);
  modport sink (input valid, dist_term, conf_term, probability, run_last,
                output ready);
endinterface

/* hdl/residue_pair_similarity_score_core.sv */
// Residue pair similarity scorer. Aligned atom pairs arrive one beat at a
// time on in_if; each pair is scored when its successor arrives, or at once
// when it ends its segment, so one input beat yields zero, one or two result
// beats on out_if, and run_last marks the final result of that input. Each
// result carries the distance and conformation terms (signed Q8.24, never
// below -128.0) and exp of their sum as Q1.16. All multiplications run on
// one shared 32x32 multiplier under a small sequencer. A scored pair passes
// through the squaring steps, the partial products for the two scale terms,
// the split of the exponent into a power of two and a remainder, and seven
// multiply and divide pairs, then the output state; when the probability
// flushes to zero, the rest of the exponent split and the multiply and
// divide pairs are skipped. The input is not ready while a beat is in work,
// and stays not ready while a result waits on out_if. The user must write
// the scale registers through cfg_we_i/cfg_idx_i/cfg_data_i only while the
// block is idle; the block itself does not enforce this. Both reset to zero.
module residue_pair_similarity_score_core
  import rpss_pkg::*;
#(
  parameter int unsigned CoordBits = COORD_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ScaleW-1:0]  cfg_data_i,
  rpss_in_if.sink            in_if,
  rpss_out_if.source         out_if
);

  localparam int unsigned DW = CoordBits;
  // Full width of a sum times a scale.
  localparam int unsigned AccW = SumW + ScaleW;
  // Width of that product after the shift down by 40.
  localparam int unsigned QW = AccW - 40;

  logic [ScaleW-1:0] dist_scale_q, conf_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_scale_q <= '0;
      conf_scale_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DIST_SCALE: dist_scale_q <= cfg_data_i;
        CFG_CONF_SCALE: conf_scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Absolute per-axis difference of two coordinates. Only the low DW bits
  // count; flipping their top bit turns two's complement into offset binary,
  // which keeps order and differences.
  function automatic logic [DW-1:0] adiff(input logic [CoordW-1:0] a,
                                          input logic [CoordW-1:0] b);
    logic [CoordMaxW-1:0] ea, eb;
    logic [DW-1:0] oa, ob;
    begin
      ea = CoordMaxW'($signed(a));
      eb = CoordMaxW'($signed(b));
      oa = ea[DW-1:0] ^ (DW'(1) << (DW - 1));
      ob = eb[DW-1:0] ^ (DW'(1) << (DW - 1));
      return (oa > ob) ? oa - ob : ob - oa;
    end
  endfunction

  function automatic logic [DW-1:0] absd(input logic [DW-1:0] a,
                                         input logic [DW-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // min(floor(prod / 2^40), 2^31).
  function automatic logic [31:0] sat_term(input logic [AccW-1:0] prod);
    logic [QW-1:0] q;
    begin
      q = prod[AccW-1:40];
      return (q > QW'(TermSat)) ? TermSat : q[31:0];
    end
  endfunction

  // Segment window: the waiting pair (centre) and the one before it.
  logic [DW-1:0] bef_q [3];
  logic [DW-1:0] cen_q [3];
  logic          cen_valid_q, cen_hasb_q;

  // The end-of-segment pair, kept for a second scoring job of the same beat.
  logic [DW-1:0] cur_q [3];
  logic [DW-1:0] b2_q [3];
  logic          hasb2_q;

  // Operands of the pair being scored.
  logic [DW-1:0] sc_q [3], sb_q [3], sa_q [3];
  logic          has_b_q, has_a_q, fin_q;
  logic          second_q; // a second scoring job of this beat is pending

  state_e state_q, state_d;
  logic [3:0] step_q;
  logic [SumW-1:0] dsq_q, ssq_q;
  logic [AccW-1:0] acc_q;
  logic [31:0] dm_q, cm_q;
  logic [31:0] x_q, r_q, p_q;
  logic [4:0] k_q;
  logic [2:0] n_q;
  logic [23:0] t_q;
  logic [ProbW-1:0] prob_q;

  // Shared multiplier.
  logic [31:0] ma, mb;
  logic [63:0] mp;
  assign mp = 64'(ma) * 64'(mb);

  // Value squared at each step: the centre itself, then its change toward
  // the pair before and toward the pair after. A missing neighbour adds zero.
  logic [DW-1:0] sqv;
  always_comb begin
    sqv = '0;
    case (step_q)
      4'd0: sqv = sc_q[0];
      4'd1: sqv = sc_q[1];
      4'd2: sqv = sc_q[2];
      4'd3: sqv = has_b_q ? absd(sc_q[0], sb_q[0]) : '0;
      4'd4: sqv = has_b_q ? absd(sc_q[1], sb_q[1]) : '0;
      4'd5: sqv = has_b_q ? absd(sc_q[2], sb_q[2]) : '0;
      4'd6: sqv = has_a_q ? absd(sc_q[0], sa_q[0]) : '0;
      4'd7: sqv = has_a_q ? absd(sc_q[1], sa_q[1]) : '0;
      4'd8: sqv = has_a_q ? absd(sc_q[2], sa_q[2]) : '0;
      default: sqv = '0;
    endcase
  end

  // Sum times scale is built from four products of 32-bit halves: steps 0..3
  // give the distance term, steps 4..7 the conformation term.
  logic [SumW-1:0] sum_op;
  logic [ScaleW-1:0] scale_op;
  assign sum_op = step_q[2] ? ssq_q : dsq_q;
  assign scale_op = step_q[2] ? conf_scale_q : dist_scale_q;

  logic [32:0] xsum;
  assign xsum = 33'(dm_q) + 33'(cm_q);

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_q)
      ST_SQ: begin
        ma = 32'(sqv);
        mb = 32'(sqv);
      end
      ST_SCALE: begin
        ma = step_q[1] ? 32'(sum_op[SumW-1:32]) : sum_op[31:0];
        mb = step_q[0] ? 32'(scale_op[ScaleW-1:32]) : scale_op[31:0];
      end
      ST_EXP_K: begin
        ma = (step_q == 4'd0) ? xsum[31:0] : 32'(k_q);
        mb = (step_q == 4'd0) ? Ln2RecipQ32 : Ln2Q24;
      end
      ST_EXP_MUL: begin
        ma = r_q;
        mb = p_q;
      end
      ST_EXP_DIV: begin
        ma = 32'(t_q);
        mb = recip_q27(n_q);
      end
      default: ;
    endcase
  end

  logic [AccW-1:0] pp;
  always_comb begin
    case (step_q[1:0])
      2'd0: pp = AccW'(mp);
      2'd1, 2'd2: pp = AccW'(mp) << 32;
      default: pp = AccW'(mp) << 64;
    endcase
  end

  // Remainder after taking k whole ln2 off the exponent; k may be one short.
  logic [31:0] r_raw;
  assign r_raw = x_q - mp[31:0];

  logic [23:0] quo;
  logic [31:0] p_next;
  logic [ProbW-1:0] prob_next;
  assign quo = mp[50:27];
  assign p_next = OneQ24 - 32'(quo);
  assign prob_next = ProbW'((33'(p_next) + (33'd1 << (k_q + 5'd7))) >> (k_q + 5'd8));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_if.valid && (cen_valid_q || in_if.is_last)) state_d = ST_SQ;
      ST_SQ: if (step_q == 4'd8) state_d = ST_SCALE;
      ST_SCALE: if (step_q == 4'd7) state_d = ST_EXP_K;
      ST_EXP_K: begin
        if (step_q == 4'd0) begin
          if (xsum >= 33'(ExpFlush)) state_d = ST_OUT;
        end else begin
          state_d = ST_EXP_MUL;
        end
      end
      ST_EXP_MUL: state_d = ST_EXP_DIV;
      ST_EXP_DIV: if (n_q == 3'd1) state_d = ST_OUT;
        else state_d = ST_EXP_MUL;
      ST_OUT: if (out_if.ready) state_d = second_q ? ST_SQ : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_if.ready = (state_q == ST_IDLE);
    out_if.valid = (state_q == ST_OUT);
    out_if.dist_term = $signed(32'd0 - dm_q);
    out_if.conf_term = $signed(32'd0 - cm_q);
    out_if.probability = prob_q;
    out_if.run_last = fin_q;
  end

  logic [DW-1:0] cur [3];
  assign cur[0] = adiff(in_if.first_x, in_if.second_x);
  assign cur[1] = adiff(in_if.first_y, in_if.second_y);
  assign cur[2] = adiff(in_if.first_z, in_if.second_z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      cen_valid_q <= 1'b0;
      cen_hasb_q <= 1'b0;
      hasb2_q <= 1'b0;
      has_b_q <= 1'b0;
      has_a_q <= 1'b0;
      fin_q <= 1'b0;
      second_q <= 1'b0;
      dsq_q <= '0;
      ssq_q <= '0;
      acc_q <= '0;
      dm_q <= '0;
      cm_q <= '0;
      x_q <= '0;
      r_q <= '0;
      p_q <= '0;
      k_q <= '0;
      n_q <= '0;
      t_q <= '0;
      prob_q <= '0;
      for (int i = 0; i < 3; i++) begin
        bef_q[i] <= '0;
        cen_q[i] <= '0;
        cur_q[i] <= '0;
        b2_q[i] <= '0;
        sc_q[i] <= '0;
        sb_q[i] <= '0;
        sa_q[i] <= '0;
      end
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          step_q <= '0;
          dsq_q <= '0;
          ssq_q <= '0;
          acc_q <= '0;
          if (in_if.valid) begin
            // The end-of-segment job scores this pair against the old centre.
            for (int i = 0; i < 3; i++) begin
              cur_q[i] <= cur[i];
              b2_q[i] <= cen_q[i];
            end
            hasb2_q <= cen_valid_q && !in_if.is_first;
            if (cen_valid_q) begin
              // The waiting centre is scored first, with this pair as successor
              // unless a new segment starts here.
              for (int i = 0; i < 3; i++) begin
                sc_q[i] <= cen_q[i];
                sb_q[i] <= bef_q[i];
                sa_q[i] <= cur[i];
              end
              has_b_q <= cen_hasb_q;
              has_a_q <= !in_if.is_first;
              fin_q <= !in_if.is_last;
              second_q <= in_if.is_last;
            end else begin
              for (int i = 0; i < 3; i++) begin
                sc_q[i] <= cur[i];
                sb_q[i] <= cen_q[i];
                sa_q[i] <= cur[i];
              end
              has_b_q <= 1'b0;
              has_a_q <= 1'b0;
              fin_q <= 1'b1;
              second_q <= 1'b0;
            end
            if (in_if.is_last) begin
              cen_valid_q <= 1'b0;
              cen_hasb_q <= 1'b0;
            end else begin
              for (int i = 0; i < 3; i++) begin
                bef_q[i] <= cen_q[i];
                cen_q[i] <= cur[i];
              end
              cen_hasb_q <= cen_valid_q && !in_if.is_first;
              cen_valid_q <= 1'b1;
            end
          end
        end
        ST_SQ: begin
          if (step_q < 4'd3) dsq_q <= dsq_q + SumW'(mp);
          else ssq_q <= ssq_q + SumW'(mp);
          step_q <= (step_q == 4'd8) ? 4'd0 : step_q + 4'd1;
          acc_q <= '0;
        end
        ST_SCALE: begin
          if (step_q[1:0] == 2'd3) begin
            if (step_q[2]) cm_q <= sat_term(acc_q + pp);
            else dm_q <= sat_term(acc_q + pp);
            acc_q <= '0;
          end else begin
            acc_q <= acc_q + pp;
          end
          step_q <= (step_q == 4'd7) ? 4'd0 : step_q + 4'd1;
        end
        ST_EXP_K: begin
          if (step_q == 4'd0) begin
            x_q <= xsum[31:0];
            k_q <= mp[36:32];
            if (xsum >= 33'(ExpFlush)) prob_q <= '0;
            else step_q <= 4'd1;
          end else begin
            if (r_raw >= Ln2Q24) begin
              k_q <= k_q + 5'd1;
              r_q <= r_raw - Ln2Q24;
            end else begin
              r_q <= r_raw;
            end
            n_q <= 3'd7;
            p_q <= OneQ24;
            step_q <= '0;
          end
        end
        ST_EXP_MUL: t_q <= mp[47:24];
        ST_EXP_DIV: begin
          p_q <= p_next;
          n_q <= n_q - 3'd1;
          if (n_q == 3'd1) prob_q <= prob_next;
        end
        ST_OUT: begin
          if (out_if.ready && second_q) begin
            second_q <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              sc_q[i] <= cur_q[i];
              sb_q[i] <= b2_q[i];
            end
            has_b_q <= hasb2_q;
            has_a_q <= 1'b0;
            fin_q <= 1'b1;
            step_q <= '0;
            dsq_q <= '0;
            ssq_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* hdl/rpss_checker.sv */
`include "assert_macros.svh"
module rpss_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [16:0] prob,
  input logic [31:0] dterm
);
  `ASSERT_CLK(a_busy, clk_i, rst_ni, (out_valid |-> !in_ready), "ready while result shown")
  `ASSERT_CLK(a_prob, clk_i, rst_ni, (out_valid |-> prob <= 17'd65536), "probability above one")
  `ASSERT_CLK(a_hold, clk_i, rst_ni, (out_valid && !out_ready |=> out_valid), "result dropped")
  `ASSERT_CLK(a_sign, clk_i, rst_ni, (out_valid |-> (dterm[31] || dterm == 32'd0)), "positive term")
endmodule

bind residue_pair_similarity_score_core rpss_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .prob(out_if.probability), .dterm(out_if.dist_term)
);
